// ===== hw/rtl/particle_pool_update_unit_defines.svh =====
// assertion macros for the particle pool update unit
`ifndef PARTICLE_POOL_UPDATE_UNIT_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppu assertion failed");
`define PPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppu assertion failed");
`else
`define PPU_ASSERT_IMP(lbl, ante, cons)
`define PPU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/ppu_pkg.sv =====
// types and constants shared by the particle pool update unit
package ppu_pkg;

	localparam logic [1:0] OP_SPAWN = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOTLIVE = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] tick_dt;
		logic [9:0]  slot_index;
		logic [47:0] spawn_position;
		logic [47:0] spawn_velocity;
		logic [47:0] spawn_accel;
		logic [31:0] spawn_sizes;
		logic [15:0] spawn_lifetime;
		logic [31:0] spawn_start_color;
		logic [31:0] spawn_end_color;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] live_total;
		logic [47:0] out_position;
		logic [15:0] out_size;
		logic [31:0] out_color;
		logic [15:0] out_age;
	} out_t;

	typedef struct packed {
		logic [47:0] position;
		logic [47:0] velocity;
		logic [47:0] accel;
		logic [15:0] size_start;
		logic [15:0] size_end;
		logic [15:0] size_now;
		logic [15:0] age;
		logic [15:0] life;
		logic [31:0] color_start;
		logic [31:0] color_end;
		logic [31:0] color_now;
	} rec_t;

	typedef enum logic [1:0] {
		RS_SLOT,
		RS_IDX,
		RS_LAST
	} rdsel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SPAWN,
		S_RD_REQ,
		S_T_TEST,
		S_T_LOAD,
		S_T_CHECK,
		S_T_DIV,
		S_T_MUL,
		S_T_APPLY,
		S_T_WRITE,
		S_FINISH,
		S_RESP
	} state_t;

	typedef struct packed {
		logic   cap;
		logic   rd_en;
		rdsel_t rd_sel;
		logic   load_rec;
		logic   div_start;
		logic   div_step;
		logic   mul_en;
		logic   wr_en;
		logic   wr_spawn;
		logic   cnt_inc;
		logic   cnt_dec;
		logic   idx_inc;
		logic   rsp_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       full;
		logic       idx_live;
		logic       more_after;
		logic       dies;
		logic       div_last;
		logic       mul_last;
	} sts_t;

endpackage

// ===== hw/rtl/ppu_ram.sv =====
// generic single write port ram with registered read
module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/ppu_ctrl.sv =====
// controller state machine of the particle pool update unit
module ppu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          rsp_stall,
	input  ppu_pkg::sts_t sts,
	output ppu_pkg::cmd_t cmd,
	output logic          req_stall,
	output logic          rsp_valid
);
	ppu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppu_pkg::S_IDLE: begin
				if (req_valid) begin
					case (sts.opcode)
						ppu_pkg::OP_SPAWN: state_d = ppu_pkg::S_SPAWN;
						ppu_pkg::OP_TICK:  state_d = ppu_pkg::S_T_TEST;
						ppu_pkg::OP_READ:  state_d = ppu_pkg::S_RD_REQ;
						default:           state_d = ppu_pkg::S_FINISH;
					endcase
				end
			end
			ppu_pkg::S_SPAWN:   state_d = ppu_pkg::S_FINISH;
			ppu_pkg::S_RD_REQ:  state_d = ppu_pkg::S_FINISH;
			ppu_pkg::S_T_TEST:  state_d = sts.idx_live ? ppu_pkg::S_T_LOAD : ppu_pkg::S_FINISH;
			ppu_pkg::S_T_LOAD:  state_d = ppu_pkg::S_T_CHECK;
			ppu_pkg::S_T_CHECK: begin
				if (sts.dies) begin
					state_d = sts.more_after ? ppu_pkg::S_T_LOAD : ppu_pkg::S_FINISH;
				end else begin
					state_d = ppu_pkg::S_T_DIV;
				end
			end
			ppu_pkg::S_T_DIV:   state_d = sts.div_last ? ppu_pkg::S_T_MUL : ppu_pkg::S_T_DIV;
			ppu_pkg::S_T_MUL:   state_d = sts.mul_last ? ppu_pkg::S_T_APPLY : ppu_pkg::S_T_MUL;
			ppu_pkg::S_T_APPLY: state_d = ppu_pkg::S_T_WRITE;
			ppu_pkg::S_T_WRITE: state_d = ppu_pkg::S_T_TEST;
			ppu_pkg::S_FINISH:  state_d = ppu_pkg::S_RESP;
			ppu_pkg::S_RESP: begin
				if (!rsp_stall) begin
					state_d = ppu_pkg::S_IDLE;
				end
			end
			default:            state_d = ppu_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = ppu_pkg::RS_IDX;
		case (state_q)
			ppu_pkg::S_IDLE:    cmd.cap = req_valid;
			ppu_pkg::S_SPAWN: begin
				cmd.wr_en    = !sts.full;
				cmd.wr_spawn = 1'b1;
				cmd.cnt_inc  = !sts.full;
			end
			ppu_pkg::S_RD_REQ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = ppu_pkg::RS_SLOT;
			end
			ppu_pkg::S_T_TEST:  cmd.rd_en = sts.idx_live;
			ppu_pkg::S_T_LOAD:  cmd.load_rec = 1'b1;
			ppu_pkg::S_T_CHECK: begin
				if (sts.dies) begin
					cmd.cnt_dec = 1'b1;
					cmd.rd_en   = sts.more_after;
					cmd.rd_sel  = ppu_pkg::RS_LAST;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			ppu_pkg::S_T_DIV:   cmd.div_step = 1'b1;
			ppu_pkg::S_T_MUL:   cmd.mul_en = 1'b1;
			ppu_pkg::S_T_WRITE: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			ppu_pkg::S_FINISH:  cmd.rsp_load = 1'b1;
			default:            cmd.rd_sel = ppu_pkg::RS_IDX;
		endcase
	end

	assign req_stall = (state_q != ppu_pkg::S_IDLE);
	assign rsp_valid = (state_q == ppu_pkg::S_RESP);
endmodule

// ===== hw/rtl/ppu_dp.sv =====
// datapath of the particle pool update unit: particle ram, divider, multiplier
module ppu_dp #(
	parameter int POOL_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ppu_pkg::in_t  req,
	input  ppu_pkg::cmd_t cmd,
	output ppu_pkg::sts_t sts,
	output ppu_pkg::out_t rsp
);
	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int RW = $bits(ppu_pkg::rec_t);

	ppu_pkg::in_t  item_q;
	ppu_pkg::out_t rsp_q, rsp_d;
	ppu_pkg::rec_t rec_q, rd_rec, wr_rec, spawn_rec;
	logic          full_q, notlive_q;
	logic [8:0]    step_q;
	logic [CW-1:0] count_q, idx_q, cm1;
	logic [16:0]   rem_q, div_sh, age_sum;
	logic [15:0]   quo_q;
	logic [3:0]    dcnt_q, mk_q, pk_s1;
	logic signed [33:0] prod_s1, prod_c, rnd_c;
	logic          pv_s1;
	logic signed [16:0] mul_a, mul_b;
	logic [1:0]    lane;
	logic [AW-1:0] raddr, waddr;
	logic [RW-1:0] rd_raw;
	logic [17:0]   shr18, lsum;
	logic signed [19:0] vsum;
	logic [15:0]   vsat, vbase;
	logic [7:0]    cs, ce;

	assign cm1 = count_q - 1'b1;

	always_comb begin
		case (cmd.rd_sel)
			ppu_pkg::RS_SLOT: raddr = AW'(item_q.slot_index);
			ppu_pkg::RS_IDX:  raddr = idx_q[AW-1:0];
			default:          raddr = cm1[AW-1:0];
		endcase
	end

	always_comb begin
		spawn_rec             = '0;
		spawn_rec.position    = item_q.spawn_position;
		spawn_rec.velocity    = item_q.spawn_velocity;
		spawn_rec.accel       = item_q.spawn_accel;
		spawn_rec.size_start  = item_q.spawn_sizes[15:0];
		spawn_rec.size_end    = item_q.spawn_sizes[31:16];
		spawn_rec.size_now    = item_q.spawn_sizes[15:0];
		spawn_rec.life        = item_q.spawn_lifetime;
		spawn_rec.color_start = item_q.spawn_start_color;
		spawn_rec.color_end   = item_q.spawn_end_color;
		spawn_rec.color_now   = item_q.spawn_start_color;
	end

	assign wr_rec = cmd.wr_spawn ? spawn_rec : rec_q;
	assign waddr  = cmd.wr_spawn ? count_q[AW-1:0] : idx_q[AW-1:0];

	ppu_ram #(
		.WIDTH(RW),
		.DEPTH(POOL_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wr_rec),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rd_raw)
	);

	assign rd_rec = ppu_pkg::rec_t'(rd_raw);

	assign age_sum = {1'b0, rec_q.age} + {8'b0, step_q};
	assign div_sh  = {rem_q[15:0], 1'b0};

	always_comb begin
		mul_a = '0;
		mul_b = $signed({1'b0, quo_q});
		lane  = 2'(mk_q - 4'd5);
		cs    = rec_q.color_start[8*mk_q[1:0] +: 8];
		ce    = rec_q.color_end[8*mk_q[1:0] +: 8];
		case (mk_q)
			4'd0, 4'd1, 4'd2, 4'd3: begin
				mul_a = $signed({9'b0, ce}) - $signed({9'b0, cs});
			end
			4'd4: begin
				mul_a = $signed({1'b0, rec_q.size_end}) - $signed({1'b0, rec_q.size_start});
			end
			4'd5, 4'd6, 4'd7: begin
				mul_a = 17'($signed(rec_q.velocity[16*lane +: 16]));
				mul_b = $signed({1'b0, item_q.tick_dt});
			end
			4'd8, 4'd9, 4'd10: begin
				lane  = 2'(mk_q - 4'd8);
				mul_a = 17'($signed(rec_q.accel[16*lane +: 16]));
				mul_b = $signed({1'b0, item_q.tick_dt});
			end
			default: mul_a = '0;
		endcase
	end

	assign prod_c = mul_a * mul_b;
	assign rnd_c  = (prod_s1 + 34'sd32768) >>> 16;
	assign shr18  = 18'(prod_s1 >>> 16);

	always_comb begin
		vbase = (pk_s1 < 4'd8) ? rec_q.position[16*2'(pk_s1 - 4'd5) +: 16]
		                       : rec_q.velocity[16*2'(pk_s1 - 4'd8) +: 16];
		vsum  = 20'($signed(vbase)) + 20'(rnd_c);
		if (vsum > 20'sd32767) begin
			vsat = 16'h7fff;
		end else if (vsum < -20'sd32768) begin
			vsat = 16'h8000;
		end else begin
			vsat = vsum[15:0];
		end
		if (pk_s1 == 4'd4) begin
			lsum = {2'b0, rec_q.size_start} + shr18;
		end else begin
			lsum = {10'b0, rec_q.color_start[8*pk_s1[1:0] +: 8]} + shr18;
		end
	end

	always_comb begin
		rsp_d            = '0;
		rsp_d.live_total = 11'(count_q);
		case (item_q.opcode)
			ppu_pkg::OP_SPAWN: rsp_d.status = full_q ? ppu_pkg::ST_FULL : ppu_pkg::ST_OK;
			ppu_pkg::OP_READ: begin
				if (notlive_q) begin
					rsp_d.status = ppu_pkg::ST_NOTLIVE;
				end else begin
					rsp_d.status       = ppu_pkg::ST_OK;
					rsp_d.out_position = rd_rec.position;
					rsp_d.out_size     = rd_rec.size_now;
					rsp_d.out_color    = rd_rec.color_now;
					rsp_d.out_age      = rd_rec.age;
				end
			end
			default:           rsp_d.status = ppu_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			pv_s1   <= 1'b0;
			dcnt_q  <= '0;
			mk_q    <= '0;
		end else begin
			if (cmd.cap) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= cm1;
			end
			if (cmd.div_start) begin
				dcnt_q <= '0;
				mk_q   <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			pv_s1 <= cmd.mul_en;
			if (cmd.mul_en) begin
				mk_q <= mk_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			item_q    <= req;
			full_q    <= (count_q >= CW'(POOL_DEPTH));
			notlive_q <= (16'(req.slot_index) >= 16'(count_q));
			step_q    <= 9'(({1'b0, req.tick_dt} + 17'd128) >> 8);
		end
		if (cmd.load_rec) begin
			rec_q <= rd_rec;
		end
		if (cmd.div_start) begin
			rec_q.age <= age_sum[15:0];
			rem_q     <= {1'b0, age_sum[15:0]};
			quo_q     <= '0;
		end else if (cmd.div_step) begin
			if (div_sh >= {1'b0, rec_q.life}) begin
				rem_q <= div_sh - {1'b0, rec_q.life};
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= div_sh;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (cmd.mul_en) begin
			prod_s1 <= prod_c;
			pk_s1   <= mk_q;
		end
		if (pv_s1) begin
			case (pk_s1)
				4'd0, 4'd1, 4'd2, 4'd3: rec_q.color_now[8*pk_s1[1:0] +: 8] <= lsum[7:0];
				4'd4:                   rec_q.size_now <= lsum[15:0];
				4'd5, 4'd6, 4'd7:       rec_q.position[16*2'(pk_s1 - 4'd5) +: 16] <= vsat;
				4'd8, 4'd9, 4'd10:      rec_q.velocity[16*2'(pk_s1 - 4'd8) +: 16] <= vsat;
				default:                rec_q.size_now <= rec_q.size_now;
			endcase
		end
		if (cmd.rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign sts.opcode     = req.opcode;
	assign sts.full       = (count_q >= CW'(POOL_DEPTH));
	assign sts.idx_live   = (idx_q < count_q);
	assign sts.more_after = (({1'b0, idx_q} + 1'b1) < {1'b0, count_q});
	assign sts.dies       = (age_sum >= {1'b0, rec_q.life});
	assign sts.div_last   = (dcnt_q == 4'd15);
	assign sts.mul_last   = (mk_q == 4'd10);
	assign rsp            = rsp_q;
endmodule

// ===== hw/rtl/particle_pool_update_unit.sv =====
// Particle pool update unit: one item at a time, one result per item. A tick handles each
// surviving particle in turn (ram read, load, age check, 16 divider steps for age/lifetime,
// 11 steps of the one shared 17x17 multiplier for the colour, size, position and velocity
// updates, apply, write back); an expiring particle is replaced by the last live one, which
// is then checked in the same slot. The single ram port pair and the shared divider and
// multiplier serve one particle at a time. The result is held until taken; no new item is
// accepted until then.
`include "particle_pool_update_unit_defines.svh"
module particle_pool_update_unit #(
	parameter int POOL_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ppu_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ppu_pkg::out_t rsp
);
	ppu_pkg::cmd_t cmd;
	ppu_pkg::sts_t sts;

	ppu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid)
	);

	ppu_dp #(
		.POOL_DEPTH(POOL_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

	`PPU_ASSERT_IMP(a_busy_while_rsp, rsp_valid, req_stall)
	`PPU_ASSERT_IMP(a_no_overfill, cmd.cnt_inc, !sts.full)
	`PPU_ASSERT_IMP(a_kill_live, cmd.cnt_dec, sts.idx_live)
	`PPU_ASSERT_NXT(a_load_after_read, cmd.rd_en && cmd.rd_sel != ppu_pkg::RS_SLOT, cmd.load_rec)
endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the particle pool update unit
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 1024;
	localparam int WD_LIMIT = 200000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	ppu_pkg::in_t   req;
	logic  rsp_valid;
	logic  rsp_stall;
	ppu_pkg::out_t  rsp;

	ppu_pkg::rec_t  pool_img [DEPTH];
	int    live_img;
	ppu_pkg::out_t  rsp_expect_q[$];
	int    err_cnt;
	int    idle_on;
	int    hold_cycles;
	int    wd_cnt;
	int    n_spawn, n_tick, n_read, n_full, n_notlive;

	particle_pool_update_unit #(.POOL_DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [47:0] vec_step(logic [47:0] a, logic [47:0] b, logic [15:0] dt);
		logic [47:0] r;
		longint av, bv, s;
		r = '0;
		for (int k = 0; k < 3; k++) begin
			av = longint'($signed(a[16*k +: 16]));
			bv = longint'($signed(b[16*k +: 16]));
			s = av + ((bv * longint'(dt) + 32768) >>> 16);
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			r[16*k +: 16] = s[15:0];
		end
		return r;
	endfunction

	function automatic longint unsigned blend(longint unsigned s, longint unsigned e,
			longint unsigned t);
		return (s * (65536 - t) + e * t) >> 16;
	endfunction

	// applies one transaction to the pool image and returns the response it should give
	function automatic ppu_pkg::out_t advance_pool(ppu_pkg::in_t it);
		ppu_pkg::out_t r;
		ppu_pkg::rec_t p;
		int unsigned step, agev;
		longint unsigned t;
		longint unsigned sz;
		int i;
		r = '0;
		case (it.opcode)
			ppu_pkg::OP_SPAWN: begin
				if (live_img >= DEPTH) begin
					r.status = ppu_pkg::ST_FULL;
				end else begin
					p = '0;
					p.position = it.spawn_position;
					p.velocity = it.spawn_velocity;
					p.accel = it.spawn_accel;
					p.size_start = it.spawn_sizes[15:0];
					p.size_end = it.spawn_sizes[31:16];
					p.size_now = it.spawn_sizes[15:0];
					p.life = it.spawn_lifetime;
					p.color_start = it.spawn_start_color;
					p.color_end = it.spawn_end_color;
					p.color_now = it.spawn_start_color;
					pool_img[live_img] = p;
					live_img++;
				end
			end
			ppu_pkg::OP_TICK: begin
				step = (int'(it.tick_dt) + 128) >> 8;
				i = 0;
				while (i < live_img) begin
					p = pool_img[i];
					agev = int'(p.age) + step;
					if (agev >= int'(p.life)) begin
						live_img--;
						pool_img[i] = pool_img[live_img];
						continue;
					end
					p.age = agev[15:0];
					t = (longint'(agev) << 16) / longint'(p.life);
					for (int k = 0; k < 4; k++)
						p.color_now[8*k +: 8] = 8'(blend(p.color_start[8*k +: 8],
							p.color_end[8*k +: 8], t));
					sz = blend(p.size_start, p.size_end, t);
					p.size_now = sz[15:0];
					p.position = vec_step(p.position, p.velocity, it.tick_dt);
					p.velocity = vec_step(p.velocity, p.accel, it.tick_dt);
					pool_img[i] = p;
					i++;
				end
			end
			ppu_pkg::OP_READ: begin
				if (int'(it.slot_index) >= live_img) begin
					r.status = ppu_pkg::ST_NOTLIVE;
				end else begin
					p = pool_img[it.slot_index];
					r.out_position = p.position;
					r.out_size = p.size_now;
					r.out_color = p.color_now;
					r.out_age = p.age;
				end
			end
			default: ;
		endcase
		r.live_total = live_img[10:0];
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	task automatic send_txn(ppu_pkg::in_t it);
		int gap;
		ppu_pkg::out_t e;
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		e = advance_pool(it);
		rsp_expect_q.push_back(e);
		case (it.opcode)
			ppu_pkg::OP_SPAWN: n_spawn++;
			ppu_pkg::OP_TICK:  n_tick++;
			ppu_pkg::OP_READ:  n_read++;
			default: ;
		endcase
		if (e.status == ppu_pkg::ST_FULL) n_full++;
		if (e.status == ppu_pkg::ST_NOTLIVE) n_notlive++;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		while (rsp_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic ppu_pkg::in_t rand_fields();
		ppu_pkg::in_t it;
		it.opcode = 2'($urandom);
		it.tick_dt = 16'($urandom);
		it.slot_index = 10'($urandom);
		it.spawn_position = 48'({$urandom, $urandom});
		it.spawn_velocity = 48'({$urandom, $urandom});
		it.spawn_accel = 48'({$urandom, $urandom});
		it.spawn_sizes = $urandom;
		it.spawn_lifetime = 16'($urandom_range(1, 65535));
		it.spawn_start_color = $urandom;
		it.spawn_end_color = $urandom;
		return it;
	endfunction

	function automatic ppu_pkg::in_t make_op(logic [1:0] op);
		ppu_pkg::in_t it;
		it = rand_fields();
		it.opcode = op;
		return it;
	endfunction

	// well-formed spawn with a random lifetime between 1 and life_hi
	function automatic ppu_pkg::in_t spawn_item(int unsigned life_hi);
		ppu_pkg::in_t it;
		it = make_op(ppu_pkg::OP_SPAWN);
		it.spawn_lifetime = 16'($urandom_range(1, life_hi));
		return it;
	endfunction

	function automatic ppu_pkg::in_t read_item(int unsigned idx);
		ppu_pkg::in_t it;
		it = make_op(ppu_pkg::OP_READ);
		it.slot_index = idx[9:0];
		return it;
	endfunction

	function automatic ppu_pkg::in_t tick_item(logic [15:0] dt);
		ppu_pkg::in_t it;
		it = make_op(ppu_pkg::OP_TICK);
		it.tick_dt = dt;
		return it;
	endfunction

	task automatic test_directed();
		ppu_pkg::in_t it;
		send_txn(read_item(0));
		send_txn(make_op(OP_UNUSED));
		it = spawn_item(65535);
		it.spawn_position = {16'h8000, 16'h7fff, 16'h8000};
		it.spawn_velocity = {16'h7fff, 16'h8000, 16'h7fff};
		it.spawn_accel = {16'h8000, 16'h7fff, 16'h8000};
		it.spawn_sizes = 32'hffff_0000;
		it.spawn_lifetime = 16'hffff;
		it.spawn_start_color = 32'h00ff_00ff;
		it.spawn_end_color = 32'hff00_ff00;
		send_txn(it);
		it = spawn_item(1);
		it.spawn_lifetime = 16'h0000;
		send_txn(it);
		it = spawn_item(65535);
		it.spawn_position = 48'hffff_ffff_ffff;
		it.spawn_velocity = 48'h0;
		it.spawn_accel = 48'hffff_ffff_ffff;
		it.spawn_sizes = 32'h0000_ffff;
		it.spawn_lifetime = 16'd2;
		it.spawn_start_color = 32'hffff_ffff;
		it.spawn_end_color = 32'h0;
		send_txn(it);
		send_txn(spawn_item(600));
		send_txn(read_item(1));
		send_txn(tick_item(16'h0000));
		send_txn(read_item(0));
		send_txn(read_item(1));
		send_txn(read_item(3));
		send_txn(read_item(4));
		send_txn(read_item(1023));
		send_txn(tick_item(16'hffff));
		send_txn(read_item(0));
		send_txn(read_item(1));
		send_txn(tick_item(16'h0080));
		send_txn(tick_item(16'h007f));
		send_txn(read_item(0));
		send_txn(make_op(OP_UNUSED));
		send_txn(tick_item(16'hffff));
		send_txn(read_item(0));
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		for (int n = 0; n < 6; n++)
			send_txn(n % 2 ? read_item($urandom_range(0, live_img)) : spawn_item(3000));
		wait_drain();
		send_txn(tick_item(16'($urandom)));
		send_txn(read_item(0));
		wait_drain();
	endtask

	task automatic test_random(int count);
		int unsigned sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < 35)
				send_txn(spawn_item(live_img > 40 ? 300 : ($urandom_range(0, 4) == 0 ? 65535 : 3000)));
			else if (sel < 58)
				send_txn(tick_item($urandom_range(0, 5) == 0 ? 16'($urandom) :
					16'($urandom_range(0, 16384))));
			else if (sel < 90)
				send_txn(read_item(live_img > 0 ? $urandom_range(0, live_img - 1) : 0));
			else if (sel < 96)
				send_txn(read_item($urandom_range(0, 1023)));
			else
				send_txn(make_op(OP_UNUSED));
		end
	endtask

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (rsp_expect_q.size() == 0) begin
				report("unexpected transaction", 64'(rsp), 64'h0);
			end else begin
				ppu_pkg::out_t e;
				e = rsp_expect_q.pop_front();
				if (rsp.status !== e.status) report("status", 64'(rsp.status), 64'(e.status));
				if (rsp.live_total !== e.live_total)
					report("live_total", 64'(rsp.live_total), 64'(e.live_total));
				if (rsp.out_position !== e.out_position)
					report("out_position", 64'(rsp.out_position), 64'(e.out_position));
				if (rsp.out_size !== e.out_size)
					report("out_size", 64'(rsp.out_size), 64'(e.out_size));
				if (rsp.out_color !== e.out_color)
					report("out_color", 64'(rsp.out_color), 64'(e.out_color));
				if (rsp.out_age !== e.out_age)
					report("out_age", 64'(rsp.out_age), 64'(e.out_age));
			end
		end
	end

	int stall_burst;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_stall <= 1'b1;
		end else if (stall_burst > 0) begin
			stall_burst--;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_burst = $urandom_range(0, 3);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			wd_cnt <= 0;
		else
			wd_cnt <= wd_cnt + 1;
		if (wd_cnt == WD_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WD_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		err_cnt = 0;
		live_img = 0;
		hold_cycles = 0;
		stall_burst = 0;
		wd_cnt = 0;
		idle_on = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(220);
		wait_drain();
		idle_on = 0;
		test_random(40);
		wait_drain();
		repeat (100) @(posedge clk);
		$display("covered %0d spawns (%0d refused as full), %0d ticks, %0d reads (%0d not live)",
			n_spawn, n_full, n_tick, n_read, n_notlive);
		$display("%0d mismatches, %0d particles live at the end", err_cnt, live_img);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ppu_pkg.sv
hw/rtl/ppu_ram.sv
hw/rtl/ppu_ctrl.sv
hw/rtl/ppu_dp.sv
hw/rtl/particle_pool_update_unit.sv
verif/tb_top.sv
